/* sv/drc_pkg.sv */
// Shared types, command codes, register indexes and reset values of the drive command controller.
`default_nettype none

package drc_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_INTERVAL  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_SPEED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_STEP     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MIN      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_MAX      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_INTERVAL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_INTERVAL  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK_PHASE   = 3'd7;

   // register reset values
   localparam logic [15:0] RST_RAMP_INTERVAL  = 16'd5;
   localparam logic [7:0]  RST_START_SPEED    = 8'd128;
   localparam logic [7:0]  RST_SERVO_STEP     = 8'd10;
   localparam logic [7:0]  RST_SERVO_MIN      = 8'd60;
   localparam logic [7:0]  RST_SERVO_MAX      = 8'd180;
   localparam logic [15:0] RST_SERVO_INTERVAL = 16'd100;
   localparam logic [15:0] RST_HOLD_INTERVAL  = 16'd50;
   localparam logic [15:0] RST_ATTACK_PHASE   = 16'd1000;
   localparam logic [17:0] RST_ATTACK_PHASE2  = 18'd2000;
   localparam logic [17:0] RST_ATTACK_PHASE3  = 18'd3000;

   // command bytes
   localparam logic [7:0] CMD_FORWARD    = 8'h66; // f
   localparam logic [7:0] CMD_BACK       = 8'h62; // b
   localparam logic [7:0] CMD_RIGHT      = 8'h72; // r
   localparam logic [7:0] CMD_LEFT       = 8'h6C; // l
   localparam logic [7:0] CMD_SPIN_RIGHT = 8'h52; // R
   localparam logic [7:0] CMD_SPIN_LEFT  = 8'h4C; // L
   localparam logic [7:0] CMD_STOP       = 8'h73; // s
   localparam logic [7:0] CMD_STOP_TURN  = 8'h64; // d
   localparam logic [7:0] CMD_SERVO_UP   = 8'h2B; // +
   localparam logic [7:0] CMD_SERVO_DOWN = 8'h2D; // -
   localparam logic [7:0] CMD_HOLD       = 8'h78; // x
   localparam logic [7:0] CMD_ATTACK     = 8'h31; // 1

   // write targets and directions
   localparam logic [1:0] TGT_B1_A  = 2'd0;
   localparam logic [1:0] TGT_B1_B  = 2'd1;
   localparam logic [1:0] TGT_B2_A  = 2'd2;
   localparam logic [1:0] TGT_SERVO = 2'd3;

   localparam logic [1:0] DIR_NONE = 2'd0;
   localparam logic [1:0] DIR_ONE  = 2'd1;
   localparam logic [1:0] DIR_TWO  = 2'd2;

   // state constants
   localparam logic [7:0] SPEED_MAX    = 8'd255;
   localparam logic [7:0] ANGLE_RESET  = 8'd90;
   localparam logic [7:0] ANGLE_SWEEP1 = 8'd60;
   localparam logic [7:0] ANGLE_SWEEP2 = 8'd90;
   localparam logic [7:0] ANGLE_SWEEP3 = 8'd180;

   localparam int MAX_WR = 4;
   localparam int CNT_W  = $clog2(MAX_WR + 1);

   typedef struct packed {
      logic [15:0] ramp_interval;
      logic [7:0]  start_speed;
      logic [7:0]  servo_step;
      logic [7:0]  servo_min;
      logic [7:0]  servo_max;
      logic [15:0] servo_interval;
      logic [15:0] hold_interval;
      logic [15:0] attack_phase;
      logic [17:0] attack_phase2;
      logic [17:0] attack_phase3;
   } cfg_type;

   typedef struct packed {
      logic [1:0] target;
      logic [7:0] value;
      logic [1:0] direction;
   } wr_type;

   typedef struct packed {
      logic [CNT_W-1:0]      count;
      wr_type [MAX_WR-1:0]   entry;
   } wr_list_type;

   function automatic wr_type mk_wr(logic [1:0] tgt, logic [7:0] val, logic [1:0] dir);
      wr_type w;
      w.target    = tgt;
      w.value     = val;
      w.direction = dir;
      return w;
   endfunction

endpackage

`default_nettype wire

/* sv/drc_csr.sv */
// Configuration registers with precomputed attack sweep phase boundaries.
`default_nettype none

module drc_csr (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [drc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [drc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output drc_pkg::cfg_type               cfg
);

   drc_pkg::cfg_type cfg_ff;
   drc_pkg::cfg_type cfg_in;
   logic [17:0]      phase2;

   assign phase2 = {1'b0, csr_wdata, 1'b0};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            drc_pkg::CSR_RAMP_INTERVAL:  cfg_in.ramp_interval  = csr_wdata;
            drc_pkg::CSR_START_SPEED:    cfg_in.start_speed    = csr_wdata[7:0];
            drc_pkg::CSR_SERVO_STEP:     cfg_in.servo_step     = csr_wdata[7:0];
            drc_pkg::CSR_SERVO_MIN:      cfg_in.servo_min      = csr_wdata[7:0];
            drc_pkg::CSR_SERVO_MAX:      cfg_in.servo_max      = csr_wdata[7:0];
            drc_pkg::CSR_SERVO_INTERVAL: cfg_in.servo_interval = csr_wdata;
            drc_pkg::CSR_HOLD_INTERVAL:  cfg_in.hold_interval  = csr_wdata;
            drc_pkg::CSR_ATTACK_PHASE: begin
               cfg_in.attack_phase  = csr_wdata;
               cfg_in.attack_phase2 = phase2;
               cfg_in.attack_phase3 = phase2 + {2'b00, csr_wdata};
            end
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_interval  <= drc_pkg::RST_RAMP_INTERVAL;
         cfg_ff.start_speed    <= drc_pkg::RST_START_SPEED;
         cfg_ff.servo_step     <= drc_pkg::RST_SERVO_STEP;
         cfg_ff.servo_min      <= drc_pkg::RST_SERVO_MIN;
         cfg_ff.servo_max      <= drc_pkg::RST_SERVO_MAX;
         cfg_ff.servo_interval <= drc_pkg::RST_SERVO_INTERVAL;
         cfg_ff.hold_interval  <= drc_pkg::RST_HOLD_INTERVAL;
         cfg_ff.attack_phase   <= drc_pkg::RST_ATTACK_PHASE;
         cfg_ff.attack_phase2  <= drc_pkg::RST_ATTACK_PHASE2;
         cfg_ff.attack_phase3  <= drc_pkg::RST_ATTACK_PHASE3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* sv/drc_core.sv */
// Input register, command decode, speed/servo state and write list generation.
`default_nettype none

module drc_core (
   input  wire                  clock,
   input  wire                  reset,
   input  drc_pkg::cfg_type     cfg,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire [7:0]            req_command,
   input  wire [31:0]           req_now_ms,
   input  wire                  list_space,
   output logic                 list_load,
   output drc_pkg::wr_list_type list
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  cmd_ff;
   logic [31:0] now_ff;

   logic [7:0]  fwd_ff, fwd_in, right_ff, right_in, left_ff, left_in;
   logic [7:0]  angle_ff, angle_in;
   logic [31:0] last_ms_ff, last_ms_in;

   logic [7:0]  upd_fwd, upd_right, upd_left, upd_angle;
   logic [31:0] upd_last_ms;

   logic [31:0] elapsed;
   logic [7:0]  cur_spd, seed_spd, bump_spd;
   logic        ramp_ok;
   logic signed [9:0] step_a, lo_a, hi_a;
   logic [7:0]  clamp_angle;
   logic        move, take_req;

   always_comb begin
      elapsed  = now_ff - last_ms_ff;
      ramp_ok  = elapsed >= {16'h0000, cfg.ramp_interval};

      case (cmd_ff)
         drc_pkg::CMD_RIGHT: cur_spd = right_ff;
         drc_pkg::CMD_LEFT:  cur_spd = left_ff;
         default:            cur_spd = fwd_ff;
      endcase
      seed_spd = (cur_spd == 8'd0) ? cfg.start_speed : cur_spd;
      bump_spd = seed_spd;
      if (ramp_ok && seed_spd != drc_pkg::SPEED_MAX) begin
         bump_spd = seed_spd + 8'd1;
      end

      // servo step, clamped low first then high
      if (cmd_ff == drc_pkg::CMD_SERVO_UP) begin
         step_a = $signed({2'b00, angle_ff}) + $signed({2'b00, cfg.servo_step});
      end else begin
         step_a = $signed({2'b00, angle_ff}) - $signed({2'b00, cfg.servo_step});
      end
      lo_a = $signed({2'b00, cfg.servo_min});
      hi_a = $signed({2'b00, cfg.servo_max});
      if (step_a < lo_a) begin
         clamp_angle = cfg.servo_min;
      end else if (step_a > hi_a) begin
         clamp_angle = cfg.servo_max;
      end else begin
         clamp_angle = step_a[7:0];
      end
   end

   always_comb begin
      upd_fwd     = fwd_ff;
      upd_right   = right_ff;
      upd_left    = left_ff;
      upd_angle   = angle_ff;
      upd_last_ms = last_ms_ff;
      list        = '0;

      case (cmd_ff)
         drc_pkg::CMD_FORWARD, drc_pkg::CMD_BACK,
         drc_pkg::CMD_SPIN_RIGHT, drc_pkg::CMD_SPIN_LEFT,
         drc_pkg::CMD_RIGHT, drc_pkg::CMD_LEFT: begin
            if (cmd_ff == drc_pkg::CMD_RIGHT) begin
               upd_right = bump_spd;
            end else if (cmd_ff == drc_pkg::CMD_LEFT) begin
               upd_left = bump_spd;
            end else begin
               upd_fwd = bump_spd;
            end
            if (ramp_ok) begin
               upd_last_ms = now_ff;
               case (cmd_ff)
                  drc_pkg::CMD_FORWARD: begin
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, bump_spd, drc_pkg::DIR_ONE);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, bump_spd, drc_pkg::DIR_ONE);
                     list.count    = drc_pkg::CNT_W'(2);
                  end
                  drc_pkg::CMD_BACK: begin
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, bump_spd, drc_pkg::DIR_TWO);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, bump_spd, drc_pkg::DIR_TWO);
                     list.count    = drc_pkg::CNT_W'(2);
                  end
                  drc_pkg::CMD_RIGHT: begin
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, bump_spd, drc_pkg::DIR_ONE);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, bump_spd, drc_pkg::DIR_ONE);
                     list.count    = drc_pkg::CNT_W'(2);
                  end
                  drc_pkg::CMD_LEFT: begin
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, bump_spd, drc_pkg::DIR_TWO);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, bump_spd, drc_pkg::DIR_ONE);
                     list.count    = drc_pkg::CNT_W'(2);
                  end
                  drc_pkg::CMD_SPIN_RIGHT: begin
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, bump_spd, drc_pkg::DIR_ONE);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, bump_spd, drc_pkg::DIR_ONE);
                     list.entry[2] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, bump_spd, drc_pkg::DIR_TWO);
                     list.count    = drc_pkg::CNT_W'(3);
                  end
                  default: begin // spin left
                     list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, bump_spd, drc_pkg::DIR_TWO);
                     list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, bump_spd, drc_pkg::DIR_TWO);
                     list.entry[2] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, bump_spd, drc_pkg::DIR_ONE);
                     list.count    = drc_pkg::CNT_W'(3);
                  end
               endcase
            end
         end
         drc_pkg::CMD_STOP: begin
            upd_fwd       = 8'd0;
            list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, 8'd0, drc_pkg::DIR_ONE);
            list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, 8'd0, drc_pkg::DIR_ONE);
            list.count    = drc_pkg::CNT_W'(2);
         end
         drc_pkg::CMD_STOP_TURN: begin
            upd_right     = 8'd0;
            upd_left      = 8'd0;
            list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_B1_A, 8'd0, drc_pkg::DIR_ONE);
            list.entry[1] = drc_pkg::mk_wr(drc_pkg::TGT_B2_A, 8'd0, drc_pkg::DIR_ONE);
            list.entry[2] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, 8'd0, drc_pkg::DIR_ONE);
            list.entry[3] = drc_pkg::mk_wr(drc_pkg::TGT_B1_B, 8'd0, drc_pkg::DIR_TWO);
            list.count    = drc_pkg::CNT_W'(4);
         end
         drc_pkg::CMD_SERVO_UP, drc_pkg::CMD_SERVO_DOWN: begin
            if (elapsed >= {16'h0000, cfg.servo_interval}) begin
               upd_last_ms   = now_ff;
               upd_angle     = clamp_angle;
               list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_SERVO, clamp_angle, drc_pkg::DIR_NONE);
               list.count    = drc_pkg::CNT_W'(1);
            end
         end
         drc_pkg::CMD_HOLD: begin
            if (elapsed >= {16'h0000, cfg.hold_interval}) begin
               upd_last_ms   = now_ff;
               list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_SERVO, angle_ff, drc_pkg::DIR_NONE);
               list.count    = drc_pkg::CNT_W'(1);
            end
         end
         drc_pkg::CMD_ATTACK: begin
            // phases are disjoint; zero phase length lands in the last one
            if (elapsed >= {14'h0000, cfg.attack_phase3}) begin
               upd_last_ms   = now_ff;
               upd_angle     = drc_pkg::ANGLE_SWEEP3;
               list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_SERVO, drc_pkg::ANGLE_SWEEP3,
                                              drc_pkg::DIR_NONE);
               list.count    = drc_pkg::CNT_W'(1);
            end else if (elapsed >= {14'h0000, cfg.attack_phase2}) begin
               upd_angle     = drc_pkg::ANGLE_SWEEP2;
               list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_SERVO, drc_pkg::ANGLE_SWEEP2,
                                              drc_pkg::DIR_NONE);
               list.count    = drc_pkg::CNT_W'(1);
            end else if (elapsed >= {16'h0000, cfg.attack_phase}) begin
               upd_angle     = drc_pkg::ANGLE_SWEEP1;
               list.entry[0] = drc_pkg::mk_wr(drc_pkg::TGT_SERVO, drc_pkg::ANGLE_SWEEP1,
                                              drc_pkg::DIR_NONE);
               list.count    = drc_pkg::CNT_W'(1);
            end
         end
         default: list = '0;
      endcase
   end

   // a command with no writes retires without waiting for the output buffer
   assign move      = in_valid_ff && (list_space || list.count == '0);
   assign list_load = move && (list.count != '0);
   assign req_ready = !in_valid_ff || move;
   assign take_req  = req_valid && req_ready;

   always_comb begin
      in_valid_in = take_req || (in_valid_ff && !move);
      fwd_in      = move ? upd_fwd     : fwd_ff;
      right_in    = move ? upd_right   : right_ff;
      left_in     = move ? upd_left    : left_ff;
      angle_in    = move ? upd_angle   : angle_ff;
      last_ms_in  = move ? upd_last_ms : last_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         fwd_ff      <= 8'd0;
         right_ff    <= 8'd0;
         left_ff     <= 8'd0;
         angle_ff    <= drc_pkg::ANGLE_RESET;
         last_ms_ff  <= 32'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         fwd_ff      <= fwd_in;
         right_ff    <= right_in;
         left_ff     <= left_in;
         angle_ff    <= angle_in;
         last_ms_ff  <= last_ms_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         cmd_ff <= req_command;
         now_ff <= req_now_ms;
      end
   end

endmodule

`default_nettype wire

/* sv/drc_out_seq.sv */
// Output buffer that shifts out one command's writes, one beat per cycle while rsp_ready is high.
`default_nettype none

module drc_out_seq (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  list_load,
   input  drc_pkg::wr_list_type list,
   output logic                 list_space,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           rsp_target,
   output logic [7:0]           rsp_value,
   output logic [1:0]           rsp_direction,
   output logic                 rsp_last
);

   logic [drc_pkg::CNT_W-1:0]           remain_ff, remain_in;
   drc_pkg::wr_type [drc_pkg::MAX_WR-1:0] entry_ff, entry_in;
   logic                                 take;

   assign rsp_valid  = remain_ff != '0;
   assign take       = rsp_valid && rsp_ready;
   assign rsp_last   = remain_ff == drc_pkg::CNT_W'(1);
   assign list_space = !rsp_valid || (take && rsp_last);

   assign rsp_target    = entry_ff[0].target;
   assign rsp_value     = entry_ff[0].value;
   assign rsp_direction = entry_ff[0].direction;

   always_comb begin
      remain_in = remain_ff;
      entry_in  = entry_ff;
      if (list_load) begin
         remain_in = list.count;
         entry_in  = list.entry;
      end else if (take) begin
         remain_in = remain_ff - drc_pkg::CNT_W'(1);
         for (int i = 0; i < drc_pkg::MAX_WR - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
      end else begin
         remain_ff <= remain_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire

/* sv/drive_command_ramp_controller_top.sv */
// Top level of the drive command ramp controller.
`default_nettype none

// Takes one command byte with its millisecond time stamp per req beat and
// answers with zero to four rsp beats (motor or servo writes), the final one
// flagged by rsp_last. A command enters an input register, is decoded
// combinationally against the speed/servo state, and its writes are loaded
// into an output buffer that shifts out one beat per cycle while rsp_ready is
// high. A command with no writes retires without waiting for the buffer; any
// other moves on only when the buffer is empty or its last beat is taken, so
// the single rsp port sets the sustained rate. Configuration registers are
// written through the csr port; the user is to do so only at idle time, which
// the block does not enforce, and a write takes effect for the next command.

module drive_command_ramp_controller_top (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_we,
   input  wire [drc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [drc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire                            req_valid,
   output logic                           req_ready,
   input  wire [7:0]                      req_command,
   input  wire [31:0]                     req_now_ms,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [1:0]                     rsp_target,
   output logic [7:0]                     rsp_value,
   output logic [1:0]                     rsp_direction,
   output logic                           rsp_last
);

   drc_pkg::cfg_type     cfg;
   drc_pkg::wr_list_type list;
   logic                 list_load;
   logic                 list_space;

   // config registers, attack phase multiples computed at write time
   drc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register, decode and state update
   drc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_now_ms  (req_now_ms),
      .list_space  (list_space),
      .list_load   (list_load),
      .list        (list)
   );

   // write buffer; frees up on the last beat so the next list loads with no gap
   drc_out_seq u_out (
      .clock         (clock),
      .reset         (reset),
      .list_load     (list_load),
      .list          (list),
      .list_space    (list_space),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_target    (rsp_target),
      .rsp_value     (rsp_value),
      .rsp_direction (rsp_direction),
      .rsp_last      (rsp_last)
   );

endmodule

`default_nettype wire

/* sv/drc_checker.sv */
// Port-level checker for the drive command controller and its bind.
`default_nettype none

module drc_checker (
   input wire       clock,
   input wire       reset,
   input wire       req_ready,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire [1:0] rsp_target,
   input wire [7:0] rsp_value,
   input wire [1:0] rsp_direction,
   input wire       rsp_last
);

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target) && $stable(rsp_value)
         && $stable(rsp_direction) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // servo writes carry no direction, motor writes always do
   a_dir_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_target == drc_pkg::TGT_SERVO) == (rsp_direction == drc_pkg::DIR_NONE)))
      else $error("direction does not match write target");

   // writes of one command come out without gaps
   a_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("gap inside a command's writes");

   // input side is open right after reset
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("req_ready low after reset");

endmodule

bind drive_command_ramp_controller_top drc_checker u_drc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_target    (rsp_target),
   .rsp_value     (rsp_value),
   .rsp_direction (rsp_direction),
   .rsp_last      (rsp_last)
);

`default_nettype wire
